FILE: design/text_console_writer_macros.svh
// Assertion macros used by the text console writer top level.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// An antecedent that must be met by a consequent in the same cycle.
`define TCW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("text console writer check failed");

// An antecedent that must be met by a consequent in the following cycle.
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("text console writer check failed");

`endif

FILE: design/tcw_pkg.sv
// Types and constants shared by the text console writer modules.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int CELL_W     = 16;

    localparam int REQ_TYPE_W   = 2;
    localparam int CODE_W       = 8;
    localparam int INDEX_W      = 11;
    localparam int CURSOR_POS_W = 11;
    localparam int ATTR_W       = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_ATTR = 1'b1;

    localparam logic [CODE_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0a;
    localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET   = 8'h0f;
    localparam logic [ATTR_W-1:0] SCROLL_ATTR_RESET = 8'h00;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [CODE_W-1:0]     char_code;
        logic [INDEX_W-1:0]    cell_index;
    } t_request;

    typedef struct packed {
        logic [CURSOR_POS_W-1:0] cursor_pos;
        logic                    scrolled;
        logic [CODE_W-1:0]       read_char;
        logic [ATTR_W-1:0]       read_attr;
    } t_result;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
    } t_sweep_ctl;

endpackage

FILE: design/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/tcw_sweep.sv
// Shared address counter and end compare that steps through runs of cells.
module tcw_sweep (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tcw_pkg::t_sweep_ctl       i_ctl,
    output logic [tcw_pkg::ADDR_W-1:0] o_addr,
    output logic                      o_last
);

    logic [tcw_pkg::ADDR_W-1:0] r_addr;
    logic [tcw_pkg::ADDR_W-1:0] r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_last <= tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
        end else if (i_ctl.load) begin
            r_addr <= i_ctl.first;
            r_last <= i_ctl.last;
        end else if (i_ctl.step) begin
            r_addr <= r_addr + tcw_pkg::ADDR_W'(1);
        end
    end

    assign o_addr = r_addr;
    assign o_last = (r_addr == r_last);

endmodule

FILE: design/text_console_writer.sv
// Top level of the text console writer: request sequencer, cursor and cell store.
//
//  Channel   Ports                                      Direction
//  request   start, busy, i_request                     in
//  result    o_result_strobe, o_result                  out
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,     in
//            i_cfg_data
//
// A put that does not scroll and an unused request type finish in the idle state without raising busy.
// A read keeps busy high for one cycle while the cell store is read.
// A clear and a scroll are both walked through the cell store
// by the one address counter.
// After reset a clearing pass zeroes the whole store with busy high.
// Every accepted request gives one result strobe; the receiver cannot stall it.
`include "text_console_writer_macros.svh"

module text_console_writer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tcw_pkg::t_request                 i_request,
    output logic                              o_result_strobe,
    output tcw_pkg::t_result                  o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_COPY,
        S_COPY_END,
        S_FILL
    } t_state;

    localparam int AW = tcw_pkg::ADDR_W;

    t_state                      r_state;
    logic [AW-1:0]               r_cursor;
    logic [tcw_pkg::COL_W-1:0]   r_col;
    logic [tcw_pkg::ATTR_W-1:0]  r_text_attr;
    logic [tcw_pkg::ATTR_W-1:0]  r_scroll_attr;
    logic                        r_strobe;
    tcw_pkg::t_result            r_result;
    logic                        r_pend;
    logic [AW-1:0]               r_pend_addr;
    logic                        r_rd_ok;

    tcw_pkg::t_sweep_ctl         sweep_ctl;
    logic [AW-1:0]               sweep_addr;
    logic                        sweep_last;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

    logic                        accept;
    logic                        is_newline;
    logic                        col_wrap;
    logic [AW:0]                 next_cursor;
    logic                        put_scroll;

    tcw_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sweep_ctl),
        .o_addr  (sweep_addr),
        .o_last  (sweep_last)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy            = (r_state != S_IDLE);
    assign accept          = start && !busy;
    assign o_cfg_ready     = 1'b1;
    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    assign is_newline  = (i_request.char_code == tcw_pkg::NEWLINE_CODE);
    assign col_wrap    = (r_col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    assign next_cursor = is_newline
                       ? ((AW+1)'(r_cursor) - (AW+1)'(r_col) + (AW+1)'(tcw_pkg::COLUMNS))
                       : ((AW+1)'(r_cursor) + (AW+1)'(1));
    assign put_scroll  = (next_cursor >= (AW+1)'(tcw_pkg::CELL_COUNT));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = sweep_addr;
        ram_wdata = '0;
        ram_raddr = sweep_addr;
        sweep_ctl = '{load: 1'b0, step: 1'b0, first: '0,
                      last: AW'(tcw_pkg::CELL_COUNT - 1)};
        unique case (r_state)
            S_INIT: begin
                ram_we         = 1'b1;
                sweep_ctl.step = 1'b1;
            end
            S_IDLE: begin
                ram_raddr = AW'(i_request.cell_index);
                if (accept && i_request.req_type == tcw_pkg::REQ_PUT) begin
                    if (!is_newline) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_cursor;
                        ram_wdata = {r_text_attr, i_request.char_code};
                    end
                    if (put_scroll) begin
                        sweep_ctl.load  = 1'b1;
                        sweep_ctl.first = AW'(tcw_pkg::COLUMNS);
                    end
                end
                if (accept && i_request.req_type == tcw_pkg::REQ_CLEAR) begin
                    sweep_ctl.load = 1'b1;
                end
            end
            S_CLEAR: begin
                ram_we         = 1'b1;
                ram_wdata      = {r_text_attr, tcw_pkg::SPACE_CODE};
                sweep_ctl.step = 1'b1;
            end
            S_READ: begin
                ram_raddr = sweep_addr;
            end
            S_COPY: begin
                ram_we         = r_pend;
                ram_waddr      = r_pend_addr;
                ram_wdata      = ram_rdata;
                sweep_ctl.step = 1'b1;
            end
            S_COPY_END: begin
                ram_we          = r_pend;
                ram_waddr       = r_pend_addr;
                ram_wdata       = ram_rdata;
                sweep_ctl.load  = 1'b1;
                sweep_ctl.first = AW'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
            end
            S_FILL: begin
                ram_we         = 1'b1;
                ram_wdata      = {r_scroll_attr, tcw_pkg::SPACE_CODE};
                sweep_ctl.step = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_cursor      <= '0;
            r_col         <= '0;
            r_text_attr   <= tcw_pkg::TEXT_ATTR_RESET;
            r_scroll_attr <= tcw_pkg::SCROLL_ATTR_RESET;
            r_strobe      <= 1'b0;
            r_pend        <= 1'b0;
        end else begin
            r_strobe    <= 1'b0;
            r_pend      <= (r_state == S_COPY);
            r_pend_addr <= AW'(sweep_addr - AW'(tcw_pkg::COLUMNS));

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tcw_pkg::REG_TEXT_ATTR:   r_text_attr   <= i_cfg_data;
                    tcw_pkg::REG_SCROLL_ATTR: r_scroll_attr <= i_cfg_data;
                    default:                  r_text_attr   <= r_text_attr;
                endcase
            end

            unique case (r_state)
                S_INIT: begin
                    if (sweep_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_request.req_type)
                            tcw_pkg::REQ_PUT: begin
                                if (put_scroll) begin
                                    r_state <= S_COPY;
                                end else begin
                                    r_cursor <= AW'(next_cursor);
                                    r_col    <= (is_newline || col_wrap)
                                              ? '0 : r_col + tcw_pkg::COL_W'(1);
                                    r_strobe <= 1'b1;
                                    r_result <= '{cursor_pos: tcw_pkg::CURSOR_POS_W'(next_cursor),
                                                  scrolled: 1'b0, read_char: '0,
                                                  read_attr: '0};
                                end
                            end
                            tcw_pkg::REQ_CLEAR: begin
                                r_state <= S_CLEAR;
                            end
                            tcw_pkg::REQ_READ: begin
                                r_rd_ok <= (i_request.cell_index < tcw_pkg::CELL_COUNT);
                                r_state <= S_READ;
                            end
                            default: begin
                                r_strobe <= 1'b1;
                                r_result <= '{cursor_pos: tcw_pkg::CURSOR_POS_W'(r_cursor),
                                              scrolled: 1'b0, read_char: '0,
                                              read_attr: '0};
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_strobe <= 1'b1;
                    r_result <= '{cursor_pos: tcw_pkg::CURSOR_POS_W'(r_cursor),
                                  scrolled: 1'b0,
                                  read_char: r_rd_ok ? ram_rdata[7:0] : '0,
                                  read_attr: r_rd_ok ? ram_rdata[15:8] : '0};
                    r_state  <= S_IDLE;
                end
                S_CLEAR: begin
                    if (sweep_last) begin
                        r_strobe <= 1'b1;
                        r_result <= '{cursor_pos: tcw_pkg::CURSOR_POS_W'(r_cursor),
                                      scrolled: 1'b0, read_char: '0, read_attr: '0};
                        r_state  <= S_IDLE;
                    end
                end
                S_COPY: begin
                    if (sweep_last) begin
                        r_state <= S_COPY_END;
                    end
                end
                S_COPY_END: begin
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    if (sweep_last) begin
                        r_cursor <= AW'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
                        r_col    <= '0;
                        r_strobe <= 1'b1;
                        r_result <= '{cursor_pos: tcw_pkg::CURSOR_POS_W'(
                                          tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS),
                                      scrolled: 1'b1, read_char: '0, read_attr: '0};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TCW_ASSERT_NEXT(a_accept_progress, accept, (r_strobe || busy))
    `TCW_ASSERT_SAME(a_cursor_range, r_strobe,
        (r_result.cursor_pos < tcw_pkg::CELL_COUNT))
    `TCW_ASSERT_SAME(a_scroll_cursor, (r_strobe && r_result.scrolled),
        (r_result.cursor_pos == tcw_pkg::CURSOR_POS_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS)))
    `TCW_ASSERT_SAME(a_pend_in_copy, r_pend,
        ((r_state == S_COPY) || (r_state == S_COPY_END)))
    `TCW_ASSERT_SAME(a_col_range, 1'b1,
        (r_col < tcw_pkg::COLUMNS))

endmodule

FILE: tb/tb_text_console_writer.sv
// Self-checking testbench for the text console writer, with its own model of cells and cursor.
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int DIRECTED_ROWS = 17;

    typedef struct packed {
        t_request   rq;
        logic [4:0] count;
        logic       has_golden;
        t_result    golden;
    } t_directed_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_request              i_request;
    logic                  o_result_strobe;
    t_result               o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [ATTR_W-1:0]     i_cfg_data;

    logic                  row_checked;
    t_result               row_golden;

    logic [CELL_W-1:0]     screen_cells [CELL_COUNT];
    int                    cursor_now;
    logic [ATTR_W-1:0]     text_attr_now;
    logic [ATTR_W-1:0]     scroll_attr_now;
    t_result               results_due [$];
    int                    fail_count;
    int                    cycle_count;
    int                    burst_left;
    t_directed_row         directed_rows [DIRECTED_ROWS];

    text_console_writer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_request       (i_request),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** text_console_writer: FAILED **");
            $finish;
        end
    end

    function automatic t_result predict_console(input t_request rq);
        t_result res;
        int      i;
        res = '0;
        case (rq.req_type)
            REQ_PUT: begin
                if (rq.char_code == NEWLINE_CODE) begin
                    cursor_now = (cursor_now / COLUMNS + 1) * COLUMNS;
                end else begin
                    screen_cells[cursor_now] = {text_attr_now, rq.char_code};
                    cursor_now++;
                end
                if (cursor_now >= CELL_COUNT) begin
                    for (i = 0; i + COLUMNS < CELL_COUNT; i++) begin
                        screen_cells[i] = screen_cells[i + COLUMNS];
                    end
                    for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
                        screen_cells[i] = {scroll_attr_now, SPACE_CODE};
                    end
                    cursor_now = CELL_COUNT - COLUMNS;
                    res.scrolled = 1'b1;
                end
            end
            REQ_CLEAR: begin
                for (i = 0; i < CELL_COUNT; i++) begin
                    screen_cells[i] = {text_attr_now, SPACE_CODE};
                end
            end
            REQ_READ: begin
                if (rq.cell_index < CELL_COUNT) begin
                    {res.read_attr, res.read_char} = screen_cells[rq.cell_index];
                end
            end
            default: ;
        endcase
        res.cursor_pos = cursor_now[CURSOR_POS_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result predicted;
        t_result want;
        if (i_rst_n) begin
            if (start && !busy) begin
                predicted = predict_console(i_request);
                results_due.push_back(row_checked ? row_golden : predicted);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_TEXT_ATTR) begin
                    text_attr_now = i_cfg_data;
                end else begin
                    scroll_attr_now = i_cfg_data;
                end
            end
            if (o_result_strobe) begin
                if (results_due.size() == 0) begin
                    $error("result with no request outstanding: %h", o_result);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (o_result.cursor_pos !== want.cursor_pos) begin
                        $error("cursor_pos: expected %0d, got %0d",
                               want.cursor_pos, o_result.cursor_pos);
                        fail_count++;
                    end
                    if (o_result.scrolled !== want.scrolled) begin
                        $error("scrolled: expected %0d, got %0d",
                               want.scrolled, o_result.scrolled);
                        fail_count++;
                    end
                    if (o_result.read_char !== want.read_char) begin
                        $error("read_char: expected %h, got %h",
                               want.read_char, o_result.read_char);
                        fail_count++;
                    end
                    if (o_result.read_attr !== want.read_attr) begin
                        $error("read_attr: expected %h, got %h",
                               want.read_attr, o_result.read_attr);
                        fail_count++;
                    end
                end
            end
        end
    end

    function automatic t_directed_row dir_row(
        input logic [REQ_TYPE_W-1:0] req, input logic [CODE_W-1:0] code,
        input logic [INDEX_W-1:0] idx, input int count, input logic has_golden,
        input int cur, input logic scr, input logic [CODE_W-1:0] ch,
        input logic [ATTR_W-1:0] at);
        t_directed_row row;
        row.rq         = '{req_type: req, char_code: code, cell_index: idx};
        row.count      = count[4:0];
        row.has_golden = has_golden;
        row.golden     = '{cursor_pos: cur[CURSOR_POS_W-1:0], scrolled: scr,
                           read_char: ch, read_attr: at};
        return row;
    endfunction

    task automatic issue_request(input t_request rq, input logic checked, input t_result golden);
        if (burst_left == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        i_request   <= rq;
        row_checked <= checked;
        row_golden  <= golden;
        start       <= 1'b1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ATTR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random_traffic(input int n_items);
        t_request rq;
        int       pick;
        int       near;
        repeat (n_items) begin
            rq.char_code  = CODE_W'($urandom_range(0, 255));
            rq.cell_index = INDEX_W'($urandom_range(0, 2047));
            pick = $urandom_range(0, 999);
            if (pick < 10) begin
                rq.req_type = REQ_CLEAR;
            end else if (pick < 30) begin
                rq.req_type = REQ_UNUSED;
            end else if (pick < 180) begin
                rq.req_type = REQ_READ;
                case ($urandom_range(0, 9))
                    0: ;
                    1, 2, 3: begin
                        near = cursor_now - $urandom_range(0, 160);
                        rq.cell_index = INDEX_W'((near < 0) ? 0 : near);
                    end
                    default: rq.cell_index = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
                endcase
            end else if (pick < 220) begin
                rq.req_type  = REQ_PUT;
                rq.char_code = NEWLINE_CODE;
            end else begin
                rq.req_type = REQ_PUT;
            end
            if ($urandom_range(0, 99) == 0) begin
                drain_results();
            end
            issue_request(rq, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        int r;
        for (r = 0; r < CELL_COUNT; r++) begin
            screen_cells[r] = '0;
        end
        cursor_now      = 0;
        text_attr_now   = TEXT_ATTR_RESET;
        scroll_attr_now = SCROLL_ATTR_RESET;
        fail_count      = 0;
        cycle_count     = 0;
        burst_left      = 0;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_request   <= '0;
        row_checked <= 1'b0;
        row_golden  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_TEXT_ATTR;
        i_cfg_data  <= '0;

        directed_rows[0]  = dir_row(REQ_READ,   8'h00, 11'd0,    1, 1'b1, 0, 1'b0, 8'h00, 8'h00);
        directed_rows[1]  = dir_row(REQ_READ,   8'h00, 11'd1999, 1, 1'b1, 0, 1'b0, 8'h00, 8'h00);
        directed_rows[2]  = dir_row(REQ_READ,   8'hff, 11'd2047, 1, 1'b1, 0, 1'b0, 8'h00, 8'h00);
        directed_rows[3]  = dir_row(REQ_UNUSED, 8'hff, 11'd2047, 1, 1'b1, 0, 1'b0, 8'h00, 8'h00);
        directed_rows[4]  = dir_row(REQ_PUT,    8'hff, 11'd0,    1, 1'b1, 1, 1'b0, 8'h00, 8'h00);
        directed_rows[5]  = dir_row(REQ_PUT,    8'h00, 11'd2047, 1, 1'b1, 2, 1'b0, 8'h00, 8'h00);
        directed_rows[6]  = dir_row(REQ_READ,   8'h00, 11'd0,    1, 1'b1, 2, 1'b0, 8'hff, 8'h0f);
        directed_rows[7]  = dir_row(REQ_READ,   8'h00, 11'd1,    1, 1'b1, 2, 1'b0, 8'h00, 8'h0f);
        directed_rows[8]  = dir_row(REQ_PUT, NEWLINE_CODE, 11'd0, 1, 1'b1, 80, 1'b0, 8'h00, 8'h00);
        directed_rows[9]  = dir_row(REQ_PUT, NEWLINE_CODE, 11'd0, 23, 1'b0, 0, 1'b0, 8'h00, 8'h00);
        directed_rows[10] = dir_row(REQ_PUT, NEWLINE_CODE, 11'd0, 1, 1'b1, 1920, 1'b1,
                                    8'h00, 8'h00);
        directed_rows[11] = dir_row(REQ_READ,   8'h00, 11'd1920, 1, 1'b1, 1920, 1'b0, 8'h20, 8'h00);
        directed_rows[12] = dir_row(REQ_READ,   8'h00, 11'd0,    1, 1'b0, 0, 1'b0, 8'h00, 8'h00);
        directed_rows[13] = dir_row(REQ_CLEAR,  8'h00, 11'd0,    1, 1'b1, 1920, 1'b0, 8'h00, 8'h00);
        directed_rows[14] = dir_row(REQ_READ,   8'h00, 11'd0,    1, 1'b1, 1920, 1'b0, 8'h20, 8'h0f);
        directed_rows[15] = dir_row(REQ_READ,   8'h00, 11'd1999, 1, 1'b1, 1920, 1'b0, 8'h20, 8'h0f);
        directed_rows[16] = dir_row(REQ_PUT,    8'h7f, 11'd0,    1, 1'b1, 1921, 1'b0, 8'h00, 8'h00);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            repeat (directed_rows[r].count) begin
                issue_request(directed_rows[r].rq, directed_rows[r].has_golden,
                              directed_rows[r].golden);
            end
        end
        drain_results();

        write_register(REG_TEXT_ATTR, 8'h00);
        write_register(REG_SCROLL_ATTR, 8'hff);
        run_random_traffic(250);
        drain_results();

        write_register(REG_TEXT_ATTR, 8'hff);
        write_register(REG_SCROLL_ATTR, 8'h00);
        run_random_traffic(250);

        repeat (3) begin
            drain_results();
            write_register(REG_SCROLL_ATTR, ATTR_W'($urandom_range(0, 255)));
            write_register(REG_TEXT_ATTR, ATTR_W'($urandom_range(0, 255)));
            run_random_traffic(250);
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** text_console_writer: PASSED **");
        end else begin
            $display("** text_console_writer: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_sweep.sv
design/text_console_writer.sv
tb/tb_text_console_writer.sv
